@@ design/tds_pkg.sv @@
`default_nettype none

package tds_pkg;

  localparam int PIX_W      = 8;
  localparam int CNT_W      = 16;
  localparam int LOOKBACK_W = 16;
  localparam int FP_W       = 18;
  localparam int CFG_W      = 18;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0]      CNT_MAX           = '1;
  localparam logic [LOOKBACK_W-1:0] LOOKBACK_RESET    = LOOKBACK_W'(4);
  localparam logic [FP_W-1:0]       FRAME_PIXELS_RESET = FP_W'(76800);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LOOKBACK     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 1'b1;

  // One stored entry per pixel position
  typedef struct packed {
    logic [PIX_W-1:0] plain;
    logic [PIX_W-1:0] final_pix;
    logic [CNT_W-1:0] count;
  } entry_t;

endpackage

`default_nettype wire

@@ design/temporal_dither_stabilizer.sv @@
`default_nettype none

// Temporal dither stabiliser. Takes one pixel word per cycle in raster order while the output is
// not stalled, and returns one output word per input word. Each word passes through stage A
// (store read), stage B (change and count) and stage C (output register). The rate is set by the
// single per-pixel store, which is read once and written at most once on every advance, with
// results of words still in flight forwarded to later words at the same position. The store is
// MAX_PIXELS entries of 32 bits (previous plain byte, previous output byte, unchanged-frame
// count). It needs no clearing pass after reset: a fill mark records how far positions have
// been written since reset, and entries at or beyond it read as zero. A stall on the output
// side holds the whole pipeline, and the input is stalled in the same cycle.
module temporal_dither_stabilizer
  import tds_pkg::*;
#(
  parameter int MAX_PIXELS = 131072
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // input words
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PIX_W-1:0]     new_plain,
  input  wire logic [PIX_W-1:0]     new_dithered,
  // output words
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PIX_W-1:0]          final_pixel,
  output logic                      frame_end
);

  localparam int AW = $clog2(MAX_PIXELS);
  // width wide enough for both the frame size register and the position count
  localparam int SW = (AW + 1 > FP_W) ? AW + 1 : FP_W;
  localparam logic [SW-1:0] MAX_SIZE = SW'(MAX_PIXELS);

  // configuration registers
  logic [LOOKBACK_W-1:0] lookback;
  logic [FP_W-1:0]       frame_pixels;

  // sequencing state
  logic [AW-1:0] pixel_position;
  logic          opening_frame;
  logic [AW:0]   fill_mark;

  // per-pixel store
  entry_t mem [MAX_PIXELS];
  entry_t mem_q;

  logic advance;
  logic accept;

  // stage A: store read in flight
  logic             a_valid;
  logic [AW-1:0]    a_pos;
  logic [PIX_W-1:0] a_plain;
  logic [PIX_W-1:0] a_dith;
  logic             a_last;
  logic             a_first;
  logic             a_hit;

  // stage B: change detected, count updated
  logic             b_valid;
  logic [AW-1:0]    b_pos;
  logic [PIX_W-1:0] b_plain;
  logic [PIX_W-1:0] b_dith;
  logic             b_last;
  logic             b_first;
  logic             b_changed;
  logic [CNT_W-1:0] b_cnt;
  logic [PIX_W-1:0] b_prev_final;

  // stage C: output register, also the last write seen by the store
  logic [AW-1:0]    c_pos;
  logic [PIX_W-1:0] c_plain;
  logic [CNT_W-1:0] c_cnt;

  // The whole pipeline moves together; only a stalled output word holds it.
  assign in_stall = out_valid & out_stall;
  assign advance  = ~in_stall;
  assign accept   = in_valid & ~in_stall;

  // ---------------------------------------------------------------------------
  // Position sequencing at the input edge
  // ---------------------------------------------------------------------------
  logic [SW-1:0] frame_size;
  logic [SW-1:0] pos_plus_one;
  logic          in_last;
  logic          in_hit;

  always_comb begin
    // A zero size acts as one pixel, an oversize one as the store depth.
    if (frame_pixels == '0) begin
      frame_size = SW'(1);
    end else if (SW'(frame_pixels) > MAX_SIZE) begin
      frame_size = MAX_SIZE;
    end else begin
      frame_size = SW'(frame_pixels);
    end
    pos_plus_one = SW'(pixel_position) + SW'(1);
    in_last      = pos_plus_one >= frame_size;
    // entries below the fill mark have been written since reset
    in_hit       = {1'b0, pixel_position} < fill_mark;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lookback     <= LOOKBACK_RESET;
      frame_pixels <= FRAME_PIXELS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOOKBACK:     lookback     <= cfg_data[LOOKBACK_W-1:0];
        REG_FRAME_PIXELS: frame_pixels <= cfg_data[FP_W-1:0];
        default:          lookback     <= lookback;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      opening_frame  <= 1'b1;
      fill_mark      <= '0;
    end else if (accept) begin
      if (in_last) begin
        pixel_position <= '0;
        opening_frame  <= 1'b0;
      end else begin
        pixel_position <= pixel_position + AW'(1);
      end
      // positions are visited in order from zero, so the written set is a prefix
      if (!in_hit) begin
        fill_mark <= pos_plus_one[AW:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Store: read at the input edge, written from stage B on the same advance
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] b_final;

  always_ff @(posedge clk) begin
    if (advance) begin
      mem_q <= mem[pixel_position];
      if (b_valid) begin
        mem[b_pos] <= '{plain: b_plain, final_pix: b_final, count: b_cnt};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_pos   <= pixel_position;
      a_plain <= new_plain;
      a_dith  <= new_dithered;
      a_last  <= in_last;
      a_first <= opening_frame;
      a_hit   <= in_hit;
    end
  end

  // Merge the store word with results still in flight. The word in B writes on the
  // next advance and the word in C wrote on the edge that issued this read, so
  // both are missing from mem_q; B is younger and wins.
  entry_t           a_entry;
  logic             a_changed;
  logic [CNT_W-1:0] a_cnt;

  always_comb begin
    if (b_valid && (b_pos == a_pos)) begin
      a_entry = '{plain: b_plain, final_pix: b_final, count: b_cnt};
    end else if (out_valid && (c_pos == a_pos)) begin
      a_entry = '{plain: c_plain, final_pix: final_pixel, count: c_cnt};
    end else if (a_hit) begin
      a_entry = mem_q;
    end else begin
      a_entry = '0;
    end

    a_changed = a_entry.plain != a_plain;
    // the first frame leaves the count as it is
    if (a_first) begin
      a_cnt = a_entry.count;
    end else if (a_changed) begin
      a_cnt = '0;
    end else if (a_entry.count == CNT_MAX) begin
      a_cnt = a_entry.count;
    end else begin
      a_cnt = a_entry.count + CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_pos        <= a_pos;
      b_plain      <= a_plain;
      b_dith       <= a_dith;
      b_last       <= a_last;
      b_first      <= a_first;
      b_changed    <= a_changed;
      b_cnt        <= a_cnt;
      b_prev_final <= a_entry.final_pix;
    end
  end

  // Adopt the new dithered byte on a change, once the pixel has been still long
  // enough, or throughout the first frame; otherwise repeat the previous output.
  always_comb begin
    if (b_first || b_changed || (b_cnt >= lookback)) begin
      b_final = b_dith;
    end else begin
      b_final = b_prev_final;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_pos       <= b_pos;
      c_plain     <= b_plain;
      c_cnt       <= b_cnt;
      final_pixel <= b_final;
      frame_end   <= b_last;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_temporal_dither_stabilizer.sv @@
module tb_temporal_dither_stabilizer
  import tds_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PIX     = 131072;
  localparam int CYCLE_LIMIT = 20_000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 44;
  // positions written during the first frame; later frames stay inside them
  localparam int FILLED      = 16;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  // Directed steps: one pixel word, a register write, a run of random words, or a
  // run that holds the plain byte fixed while the dithered byte wanders
  typedef enum {ROW_PIXEL, ROW_WRITE, ROW_RANDOM, ROW_HOLD} row_kind_e;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } pixel_word_t;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    int unsigned           value;   // write data, or word count for runs
    logic [PIX_W-1:0]      plain;
    logic [PIX_W-1:0]      dith;
    bit                    typed;   // use the word below instead of the predictor
    pixel_word_t           want;
  } script_row_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_LOOKBACK;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     new_plain    = '0;
  logic [PIX_W-1:0]     new_dithered = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [PIX_W-1:0]     final_pixel;
  logic                 frame_end;

  // Predictor copy of the registers and of the per-position stores
  logic [LOOKBACK_W-1:0] lookback_now   = LOOKBACK_RESET;
  logic [FP_W-1:0]       frame_size_now = FRAME_PIXELS_RESET;
  bit [PIX_W-1:0]        plain_store [MAX_PIX];
  bit [PIX_W-1:0]        shown_store [MAX_PIX];
  bit [CNT_W-1:0]        still_store [MAX_PIX];
  int unsigned           pixel_at      = 0;
  bit                    opening_frame = 1'b1;

  pixel_word_t due_words [$];
  int          mismatches = 0;
  int unsigned cycles     = 0;
  int          send_pct   = 0;
  int          stall_pct  = 0;
  bit          typed_on   = 1'b0;
  pixel_word_t typed_word;

  always #5 clk = ~clk;

  temporal_dither_stabilizer #(
    .MAX_PIXELS(MAX_PIX)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .new_plain    (new_plain),
    .new_dithered (new_dithered),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .final_pixel  (final_pixel),
    .frame_end    (frame_end)
  );

  // Work out the output word for one accepted pixel and advance the stores.
  // A changed plain byte clears the run and adopts the dithered byte at once;
  // an unchanged one lengthens the run (saturating) and only adopts once the
  // run has reached the lookback, repeating the previous output until then.
  function automatic void stabilise_pixel(input logic [PIX_W-1:0] plain,
                                          input logic [PIX_W-1:0] dith,
                                          output pixel_word_t word);
    int unsigned size;
    int unsigned pos;
    int unsigned run;
    bit          moved;
    size = (frame_size_now == 0) ? 1 :
           ((frame_size_now > MAX_PIX) ? MAX_PIX : int'(frame_size_now));
    pos  = (pixel_at >= MAX_PIX) ? MAX_PIX - 1 : pixel_at;
    if (opening_frame) begin
      word.pix = dith;
    end else begin
      run   = int'(still_store[pos]);
      moved = (plain_store[pos] != plain);
      if (moved) begin
        run = 0;
      end else if (run < CNT_MAX) begin
        run++;
      end
      still_store[pos] = run[CNT_W-1:0];
      word.pix = (moved || run >= lookback_now) ? dith : shown_store[pos];
    end
    plain_store[pos] = plain;
    shown_store[pos] = word.pix;
    word.last = (pos + 1 >= size);
    if (word.last) begin
      pixel_at      = 0;
      opening_frame = 1'b0;
    end else begin
      pixel_at = pos + 1;
    end
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // Mostly repeat the plain byte this position saw last frame, so that runs of
  // unchanged frames build up; otherwise pick a fresh byte.
  function automatic logic [PIX_W-1:0] pick_plain();
    if ($urandom_range(3) != 0) begin
      return plain_store[pixel_at];
    end
    return PIX_W'($urandom_range(255));
  endfunction

  // Sample everything at the rising edge: register writes and accepted words
  // advance the predictor, accepted output words are checked in order.
  always @(posedge clk) begin
    pixel_word_t want;
    pixel_word_t got;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LOOKBACK:     lookback_now   = cfg_data[LOOKBACK_W-1:0];
          REG_FRAME_PIXELS: frame_size_now = cfg_data[FP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        stabilise_pixel(new_plain, new_dithered, want);
        if (typed_on) begin
          want = typed_word;
        end
        due_words.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{pix: final_pixel, last: frame_end};
        if (due_words.size() == 0) begin
          note_mismatch("unexpected word", 0, int'(got));
        end else begin
          want = due_words.pop_front();
          if (want.pix !== got.pix) begin
            note_mismatch("final_pixel", int'(want.pix), int'(got.pix));
          end
          if (want.last !== got.last) begin
            note_mismatch("frame_end", int'(want.last), int'(got.last));
          end
        end
      end
    end
  end

  // Stall the output side at random; never during reset
  always @(negedge clk) begin
    out_stall <= !rst && stall_pct != 0 && $urandom_range(99) < stall_pct;
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL temporal_dither_stabilizer");
      $finish;
    end
  end

  // Offer one word, with a random gap first; return at the falling edge after
  // it has been taken, leaving valid high for the caller to reuse or drop.
  task automatic send_word(input logic [PIX_W-1:0] plain, input logic [PIX_W-1:0] dith);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    new_plain    <= plain;
    new_dithered <= dith;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    script_row_t script [$];
    idle_mode_e  mode;
    int unsigned lb_pick;
    int unsigned fp_pick;

    script = '{
      // First frame after reset: the dithered byte passes straight through
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'h00, 8'hFF, 1'b1, '{8'hFF, 1'b0}},
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'hFF, 8'h00, 1'b1, '{8'h00, 1'b0}},
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'hA5, 8'h5A, 1'b1, '{8'h5A, 1'b0}},
      // Oversize frame still inside the first frame, filling the used positions
      '{ROW_WRITE, REG_FRAME_PIXELS, 'h3FFFF, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_RANDOM, REG_LOOKBACK, FILLED - 4, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      // Shrink below the current position: this pixel ends the first frame
      '{ROW_WRITE, REG_FRAME_PIXELS, 2, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'h11, 8'h22, 1'b1, '{8'h22, 1'b1}},
      // One-pixel frames at position zero with the reset lookback of four
      '{ROW_WRITE, REG_FRAME_PIXELS, 1, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'h00, 8'h11, 1'b1, '{8'hFF, 1'b1}},
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'h00, 8'h22, 1'b1, '{8'hFF, 1'b1}},
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'h00, 8'h33, 1'b1, '{8'hFF, 1'b1}},
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'h00, 8'h44, 1'b1, '{8'h44, 1'b1}},
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'h80, 8'h55, 1'b1, '{8'h55, 1'b1}},
      // Zero lookback: an unchanged pixel adopts the new byte at once
      '{ROW_WRITE, REG_LOOKBACK, 0, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'h80, 8'h66, 1'b1, '{8'h66, 1'b1}},
      // Widest lookback: an unchanged pixel keeps repeating its previous output
      '{ROW_WRITE, REG_LOOKBACK, 65535, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'h80, 8'h77, 1'b1, '{8'h66, 1'b1}},
      // Zero frame size behaves as one pixel per frame
      '{ROW_WRITE, REG_FRAME_PIXELS, 0, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_PIXEL, REG_LOOKBACK, 0, 8'h7F, 8'h01, 1'b1, '{8'h01, 1'b1}},
      // Shrink the frame below the current position: the next pixel ends it
      '{ROW_WRITE, REG_LOOKBACK, 2, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_WRITE, REG_FRAME_PIXELS, 8, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_RANDOM, REG_LOOKBACK, 5, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_WRITE, REG_FRAME_PIXELS, 3, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      '{ROW_RANDOM, REG_LOOKBACK, 2, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0}},
      // Hold the plain byte so the runs build past the lookback
      '{ROW_HOLD, REG_LOOKBACK, 20, 8'h80, 8'h00, 1'b0, '{8'h00, 1'b0}}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[r]) begin
      typed_on   = script[r].typed;
      typed_word = script[r].want;
      case (script[r].kind)
        ROW_WRITE: begin
          drain();
          write_reg(script[r].idx, script[r].value);
        end
        ROW_PIXEL:  send_word(script[r].plain, script[r].dith);
        ROW_RANDOM: repeat (script[r].value) send_word(pick_plain(), 8'($urandom_range(255)));
        ROW_HOLD:   repeat (script[r].value) send_word(script[r].plain, 8'($urandom_range(255)));
        default: ;
      endcase
    end
    typed_on = 1'b0;

    // Random phases: new settings at each idle boundary (which usually falls
    // mid-frame), then a stretch of words under one idling pattern. Frame sizes
    // stay within the positions written during the first frame.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case ($urandom_range(9))
        0:       lb_pick = 0;
        1:       lb_pick = 65535;
        2:       lb_pick = $urandom_range(65535);
        default: lb_pick = $urandom_range(1, 6);
      endcase
      case ($urandom_range(9))
        0:       fp_pick = 0;
        1:       fp_pick = FILLED;
        default: fp_pick = $urandom_range(1, 12);
      endcase
      write_reg(REG_LOOKBACK, lb_pick);
      write_reg(REG_FRAME_PIXELS, fp_pick);
      mode = idle_mode_e'(ph % 4);
      case (mode)
        IDLE_NONE:     begin send_pct = 0;  stall_pct = 0;  end
        IDLE_SENDER:   begin send_pct = 53; stall_pct = 0;  end
        IDLE_RECEIVER: begin send_pct = 0;  stall_pct = 53; end
        IDLE_BOTH:     begin send_pct = 30; stall_pct = 30; end
        default: ;
      endcase
      repeat (PHASE_WORDS) send_word(pick_plain(), 8'($urandom_range(255)));
    end

    // Wait for the tail, then keep watching to catch stray words
    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS temporal_dither_stabilizer");
    end else begin
      $display("FAIL temporal_dither_stabilizer");
    end
    $finish;
  end

endmodule
